// ===== src/sswb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sswb_pkg;

	localparam int unsigned WINDOW_BITS = 1024;
	localparam int unsigned SEQ_W       = 31;
	localparam int unsigned OP_W        = 2;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned BIT_W       = $clog2(BYTE_W);
	localparam int unsigned SLOT_W      = $clog2(WINDOW_BITS);
	localparam int unsigned ROWS        = WINDOW_BITS / BYTE_W;
	localparam int unsigned ROW_AW      = SLOT_W - BIT_W;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SWEEP,
		ST_SWEEP_WR,
		ST_SET_RD,
		ST_SET_WR
	} sswb_state_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [SEQ_W-1:0] seq_num;
	} sswb_in_t;

	typedef struct packed {
		logic             result_flag;
		logic [SEQ_W-1:0] low_seq;
		logic [SEQ_W-1:0] high_seq;
	} sswb_out_t;

	typedef struct packed {
		logic              rd;
		logic              wr;
		logic              inval;
		logic              clr_all;
		logic [ROW_AW-1:0] addr;
		logic [BYTE_W-1:0] wdata;
	} sswb_mem_req_t;

endpackage

`default_nettype wire

// ===== src/sswb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sswb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/sswb_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sswb_store import sswb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sswb_mem_req_t     req,
	output logic      [BYTE_W-1:0] rd_data
);

	// per-row valid: an invalid row reads as zero
	logic [ROWS-1:0]   vld_q;
	logic [ROWS-1:0]   vld_d;
	logic              rd_vld_q;
	logic [BYTE_W-1:0] ram_rdata;

	always_comb begin
		vld_d = vld_q;
		if (req.clr_all) begin
			vld_d = '0;
		end
		if (req.inval) begin
			vld_d[req.addr] = 1'b0;
		end
		if (req.wr) begin
			vld_d[req.addr] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
			if (req.rd) begin
				rd_vld_q <= vld_q[req.addr];
			end
		end
	end

	sswb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(ROWS)
	) u_ram (
		.clk   (clk),
		.we    (req.wr),
		.waddr (req.addr),
		.wdata (req.wdata),
		.re    (req.rd),
		.raddr (req.addr),
		.rdata (ram_rdata)
	);

	assign rd_data = rd_vld_q ? ram_rdata : '0;

endmodule

`default_nettype wire

// ===== src/sliding_sequence_window_bitmap_unit.sv =====
// Sliding sequence window bitmap.
// Input channel in_valid/in_ready/in_data carries one request: an op (insert,
// remove, query) and a sequence number. Output channel out_valid/out_ready/
// out_data returns exactly one result per request: the flag and the window
// bounds after the request.
// One request is in flight at a time. For most requests the accept cycle
// reads the bitmap row, the next updates it and registers the result, and
// the block returns to idle before it takes a new request.
// An insert that slides the window by fewer than WINDOW_BITS numbers also
// sweeps the rows that leave the window: a fully dropped row is invalidated
// through its valid flag, a partly dropped row is read and written back,
// and then the new bit is set by a read and a write. Larger slides clear
// the bitmap at once through the row valid flags.
// The bitmap lives in one row memory with registered read; the row
// read-modify-write sets the rate.
// Reset clears the bitmap and sets both window bounds to zero; the block is
// ready as soon as reset is released.
// in_ready is high only when idle and the output register is empty or
// being drained, so a stalled receiver holds off new requests.
`timescale 1ns / 1ps
`default_nettype none

module sliding_sequence_window_bitmap_unit import sswb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire sswb_in_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output sswb_out_t      out_data
);

	sswb_state_t       state_q, state_d;
	logic [OP_W-1:0]   op_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [SEQ_W-1:0]  low_q, high_q;
	logic [SEQ_W-1:0]  p_q, e_q;
	logic              out_valid_q;
	sswb_out_t         out_q;

	sswb_mem_req_t     req;
	logic [BYTE_W-1:0] rd_data;

	logic [ROW_AW-1:0] row_s, row_p;
	logic [BIT_W-1:0]  bit_s, p_lo, hi;
	logic [BYTE_W-1:0] bmask, cmask;
	logic [SEQ_W-1:0]  seq_off, nlow, nhigh, e_new, p_end, low_d, high_d;
	logic              below, in_win, hit, slide, big, ins_ok, last_row, full;
	logic              finish, res_flag, win_upd, sweep_load, p_adv;

	sswb_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	// evaluation of the latched request
	assign row_s   = seq_q[SLOT_W-1:BIT_W];
	assign bit_s   = seq_q[BIT_W-1:0];
	assign bmask   = BYTE_W'(1) << bit_s;
	assign below   = seq_q < low_q;
	assign in_win  = !below && (seq_q <= high_q);
	assign hit     = (rd_data & bmask) != '0;
	assign seq_off = seq_q - low_q;
	assign slide   = seq_off >= SEQ_W'(WINDOW_BITS);
	assign big     = seq_off >= SEQ_W'(2 * WINDOW_BITS - 1);
	assign ins_ok  = !below && !(in_win && hit);
	assign nlow    = seq_q - SEQ_W'(WINDOW_BITS - 1);
	assign e_new   = seq_q - SEQ_W'(WINDOW_BITS);
	assign nhigh   = (seq_q > high_q) ? seq_q : high_q;

	// sweep over the dropped numbers p_q..e_q, one row at a time
	assign row_p    = p_q[SLOT_W-1:BIT_W];
	assign p_lo     = p_q[BIT_W-1:0];
	assign p_end    = {p_q[SEQ_W-1:BIT_W], {BIT_W{1'b1}}};
	assign last_row = e_q <= p_end;
	assign hi       = last_row ? e_q[BIT_W-1:0] : {BIT_W{1'b1}};
	assign full     = (p_lo == '0) && (hi == {BIT_W{1'b1}});

	always_comb begin
		for (int i = 0; i < BYTE_W; i++) begin
			cmask[i] = (BIT_W'(i) >= p_lo) && (BIT_W'(i) <= hi);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (op_q == OP_INSERT && ins_ok && slide && !big) begin
					state_d = ST_SWEEP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (!full) begin
					state_d = ST_SWEEP_WR;
				end else if (last_row) begin
					state_d = ST_SET_RD;
				end
			end
			ST_SWEEP_WR: begin
				state_d = last_row ? ST_SET_RD : ST_SWEEP;
			end
			ST_SET_RD: state_d = ST_SET_WR;
			ST_SET_WR: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req        = '0;
		in_ready   = 1'b0;
		finish     = 1'b0;
		res_flag   = 1'b0;
		win_upd    = 1'b0;
		sweep_load = 1'b0;
		p_adv      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				req.rd   = in_valid && in_ready;
				req.addr = in_data.seq_num[SLOT_W-1:BIT_W];
			end
			ST_EVAL: begin
				req.addr = row_s;
				finish   = 1'b1;
				case (op_q)
					OP_INSERT: begin
						if (ins_ok) begin
							res_flag = 1'b1;
							win_upd  = 1'b1;
							if (slide && !big) begin
								finish     = 1'b0;
								sweep_load = 1'b1;
							end else if (big) begin
								req.wr      = 1'b1;
								req.clr_all = 1'b1;
								req.wdata   = bmask;
							end else begin
								req.wr    = 1'b1;
								req.wdata = rd_data | bmask;
							end
						end
					end
					OP_REMOVE: begin
						if (in_win) begin
							res_flag  = 1'b1;
							req.wr    = 1'b1;
							req.wdata = rd_data & ~bmask;
						end
					end
					OP_QUERY: res_flag = in_win && hit;
					default:  res_flag = 1'b0;
				endcase
			end
			ST_SWEEP: begin
				req.addr = row_p;
				if (full) begin
					req.inval = 1'b1;
					p_adv     = 1'b1;
				end else begin
					req.rd = 1'b1;
				end
			end
			ST_SWEEP_WR: begin
				req.addr  = row_p;
				req.wr    = 1'b1;
				req.wdata = rd_data & ~cmask;
				p_adv     = 1'b1;
			end
			ST_SET_RD: begin
				req.addr = row_s;
				req.rd   = 1'b1;
			end
			ST_SET_WR: begin
				req.addr  = row_s;
				req.wr    = 1'b1;
				req.wdata = rd_data | bmask;
				finish    = 1'b1;
				res_flag  = 1'b1;
			end
			default: req = '0;
		endcase
	end

	assign low_d  = (win_upd && slide) ? nlow : low_q;
	assign high_d = win_upd ? nhigh : high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			low_q       <= '0;
			high_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			low_q   <= low_d;
			high_q  <= high_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= in_data.op;
			seq_q <= in_data.seq_num;
		end
		if (sweep_load) begin
			p_q <= low_q;
			e_q <= e_new;
		end else if (p_adv) begin
			p_q <= {p_q[SEQ_W-1:BIT_W] + (SEQ_W - BIT_W)'(1), {BIT_W{1'b0}}};
		end
		if (finish) begin
			out_q.result_flag <= res_flag;
			out_q.low_seq     <= low_d;
			out_q.high_seq    <= high_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EVAL))
		else $error("accepted request did not move to evaluation");

	a_finish_empty: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> !out_valid_q)
		else $error("result produced while output register full");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP || state_q == ST_SWEEP_WR) |-> (p_q <= e_q))
		else $error("sweep pointer past end of dropped range");

	a_window_span: assert property (@(posedge clk) disable iff (!arst_n)
		(high_q >= low_q) && ((high_q - low_q) < SEQ_W'(WINDOW_BITS)))
		else $error("window bounds out of order or too wide");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import sswb_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned SEQ_MAX = 32'h7FFF_FFFF;
	localparam int unsigned TAIL_CYCLES = 2 * ROWS + 40;

	typedef struct {
		sswb_in_t req;
		bit       drain_first;
	} pending_req_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	sswb_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	sswb_out_t out_data;

	pending_req_t request_q[$];
	sswb_out_t    window_status_q[$];

	bit [WINDOW_BITS-1:0] seen_map;
	int unsigned win_low;
	int unsigned win_high;
	int unsigned gen_high;

	int n_errors;
	int n_checked;
	int op_count[4];
	int n_fresh_inserts;

	sliding_sequence_window_bitmap_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #6 clk = ~clk;

	function automatic sswb_out_t apply_window_op(sswb_in_t req);
		sswb_out_t   res;
		int unsigned s;
		int unsigned old_low;
		int unsigned span;
		bit          hit;
		s   = req.seq_num;
		hit = 1'b0;
		case (req.op)
			OP_INSERT: begin
				if (s >= win_low && !(s <= win_high && seen_map[SLOT_W'(s)])) begin
					if (s > win_high)
						win_high = s;
					if (win_high - win_low + 1 > WINDOW_BITS) begin
						old_low = win_low;
						win_low = win_high - WINDOW_BITS + 1;
						span    = win_low - old_low;
						if (span >= WINDOW_BITS)
							seen_map = '0;
						else
							for (int unsigned i = 0; i < span; i++)
								seen_map[SLOT_W'(old_low + i)] = 1'b0;
					end
					seen_map[SLOT_W'(s)] = 1'b1;
					hit = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (s >= win_low && s <= win_high) begin
					seen_map[SLOT_W'(s)] = 1'b0;
					hit = 1'b1;
				end
			end
			OP_QUERY: begin
				hit = s >= win_low && s <= win_high && seen_map[SLOT_W'(s)];
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		res.result_flag = hit;
		res.low_seq     = win_low[SEQ_W-1:0];
		res.high_seq    = win_high[SEQ_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		n_errors++;
	endtask

	task automatic add_req(input logic [OP_W-1:0] op, input int unsigned seq,
			input bit drain_first = 1'b0);
		pending_req_t p;
		p.req.op          = op;
		p.req.seq_num     = seq[SEQ_W-1:0];
		p.drain_first     = drain_first;
		request_q.push_back(p);
		if (op == OP_INSERT && seq > gen_high)
			gen_high = seq;
	endtask

	// sender: bursts and gaps, optional pause until all results are back
	int unsigned burst_left = 1;
	int unsigned gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				window_status_q.push_back(apply_window_op(in_data));
				op_count[in_data.op]++;
				request_q.pop_front();
			end
			if (!(in_valid && !in_ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (request_q.size() != 0 &&
						!(request_q[0].drain_first && window_status_q.size() != 0)) begin
					in_valid <= 1'b1;
					in_data  <= request_q[0].req;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern in phases, plus one long hold-off
	int unsigned rdy_mode    = 0;
	int unsigned rdy_left    = 50;
	int unsigned hold_left   = 0;
	bit          hold_done   = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (window_status_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result %p", out_data));
				end else begin
					if (out_data.result_flag !== window_status_q[0].result_flag)
						report_mismatch($sformatf("result_flag got %0b want %0b",
							out_data.result_flag, window_status_q[0].result_flag));
					if (out_data.low_seq !== window_status_q[0].low_seq)
						report_mismatch($sformatf("low_seq got %0d want %0d",
							out_data.low_seq, window_status_q[0].low_seq));
					if (out_data.high_seq !== window_status_q[0].high_seq)
						report_mismatch($sformatf("high_seq got %0d want %0d",
							out_data.high_seq, window_status_q[0].high_seq));
					window_status_q.pop_front();
				end
				n_checked++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && n_checked >= 500) begin
				hold_done = 1'b1;
				hold_left = 400;
				out_ready <= 1'b0;
			end else begin
				if (rdy_left == 0) begin
					rdy_mode = $urandom_range(0, 2);
					rdy_left = $urandom_range(20, 120);
				end else begin
					rdy_left--;
				end
				case (rdy_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		#30_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int unsigned lo;
		int unsigned seq;
		int unsigned r;
		seen_map = '0;
		win_low  = 0;
		win_high = 0;
		gen_high = 0;

		// directed
		add_req(OP_QUERY, 0);
		add_req(OP_INSERT, 0);
		add_req(OP_INSERT, 0);
		add_req(OP_QUERY, 0);
		add_req(OP_REMOVE, 0);
		add_req(OP_QUERY, 0);
		add_req(OP_INSERT, 7);
		add_req(OP_INSERT, 1023);
		add_req(OP_INSERT, 1024);
		add_req(OP_INSERT, 0);
		add_req(OP_QUERY, 1024);
		add_req(OP_REMOVE, 5000);
		add_req(OP_QUERY, 5000);
		add_req(OP_UNUSED, SEQ_MAX);
		add_req(OP_INSERT, 1030);
		add_req(OP_INSERT, 2530);
		add_req(OP_INSERT, 4530);
		add_req(OP_INSERT, 104530);
		add_req(OP_QUERY, 104530);
		add_req(OP_QUERY, 4530);
		add_req(OP_REMOVE, 104530 - 1023);
		add_req(OP_INSERT, 104530 - 1023);
		add_req(OP_INSERT, 104543);
		add_req(OP_QUERY, 104530 - 1023, 1'b1);

		// random, mostly around the live window
		for (int k = 0; k < 1400; k++) begin
			lo  = (gen_high >= WINDOW_BITS - 1) ? gen_high - (WINDOW_BITS - 1) : 0;
			r   = $urandom_range(0, 99);
			seq = lo + $urandom_range(0, gen_high - lo);
			if (r < 40)
				add_req(OP_INSERT, seq);
			else if (r < 55)
				add_req(OP_INSERT, gen_high + $urandom_range(1, 64));
			else if (r < 59)
				add_req(OP_INSERT, gen_high + $urandom_range(65, 2100));
			else if (r < 60)
				add_req(OP_INSERT, gen_high + $urandom_range(2101, 1 << 22));
			else if (r < 72)
				add_req(OP_REMOVE, seq);
			else if (r < 86)
				add_req(OP_QUERY, seq);
			else if (r < 90)
				add_req(($urandom_range(0, 1) == 0) ? OP_QUERY : OP_REMOVE,
					$urandom & SEQ_MAX);
			else if (r < 92)
				add_req(OP_UNUSED, $urandom & SEQ_MAX);
			else if (r < 95)
				add_req(OP_INSERT, (lo > 0) ? $urandom_range(0, lo - 1) : seq);
			else
				add_req(OP_W'(OP_INSERT + $urandom_range(0, 2)),
					(lo >= 8) ? lo + $urandom_range(0, 16) - 8 : gen_high + 1);
			if (k % 200 == 199)
				request_q[$].drain_first = 1'b1;
		end

		// top of the sequence space
		add_req(OP_INSERT, SEQ_MAX);
		add_req(OP_QUERY, SEQ_MAX);
		add_req(OP_REMOVE, SEQ_MAX - 1023);
		add_req(OP_INSERT, SEQ_MAX - 1023);
		add_req(OP_INSERT, SEQ_MAX);
		add_req(OP_QUERY, SEQ_MAX - 1023);
		add_req(OP_INSERT, SEQ_MAX - 1024);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (request_q.size() != 0 || in_valid || window_status_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d inserts, %0d removes, %0d queries, %0d unused-op requests",
			op_count[OP_INSERT], op_count[OP_REMOVE], op_count[OP_QUERY], op_count[OP_UNUSED]);
		$display("%0d results checked, final window [%0d, %0d], %0d mismatches",
			n_checked, win_low, win_high, n_errors);
		if (n_errors == 0 && window_status_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
